// File: rtl/core/http_request_header_checker_unit_defines.svh
// Assertion macros used by hrhc_checker.sv.
`ifndef HTTP_REQUEST_HEADER_CHECKER_UNIT_DEFINES_SVH
`define HTTP_REQUEST_HEADER_CHECKER_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define HRHC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Implication checked on every edge, reset included.
`define HRHC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// File: rtl/core/hrhc_pkg.sv
// ----------------------------------------------------------------------------
// hrhc_pkg
// Types and constants of the HTTP request head checker.
// ----------------------------------------------------------------------------
package hrhc_pkg;
  localparam int MaxMethodLen = 7;
  localparam int MethodIdxW = $clog2(MaxMethodLen + 1);
  localparam logic [13:0] MaxLineReset = 14'd8000;

  typedef enum logic [3:0] {
    PH_METHOD, PH_TARGET, PH_PROTO, PH_MAJOR, PH_DOT, PH_MINOR, PH_REQ_CR,
    PH_REQ_LF, PH_LINE_START, PH_LINE_LF, PH_NAME, PH_VALUE, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_PARSING, ST_COMPLETE, ST_BAD_REQUEST, ST_NOT_IMPL, ST_URI_LONG, ST_FIELD_LONG
  } status_e;

  typedef enum logic [2:0] {
    M_GET, M_HEAD, M_PUT, M_DELETE, M_POST
  } method_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] method_code;
    logic [3:0] major_version;
    logic [3:0] minor_version;
    logic [7:0] field_count;
  } res_t;

  function automatic logic is_vchar(logic [7:0] b);
    return (b >= 8'h21) && (b <= 8'h7e);
  endfunction

  function automatic logic is_tchar(logic [7:0] b);
    logic dl;
    dl = (b == 8'h22) || (b == 8'h28) || (b == 8'h29) || (b == 8'h2c) ||
         (b == 8'h2f) || (b == 8'h3a) || (b == 8'h3b) || (b == 8'h3c) ||
         (b == 8'h3e) || (b == 8'h3d) || (b == 8'h3f) || (b == 8'h40) ||
         (b == 8'h5b) || (b == 8'h5c) || (b == 8'h5d) || (b == 8'h7b) ||
         (b == 8'h7d);
    return is_vchar(b) && !dl;
  endfunction

  function automatic logic [7:0] proto_char(logic [2:0] i);
    case (i)
      3'd0: return 8'h48;
      3'd1: return 8'h54;
      3'd2: return 8'h54;
      3'd3: return 8'h50;
      3'd4: return 8'h2f;
      default: return 8'h00;
    endcase
  endfunction
endpackage

// File: rtl/core/hrhc_stream_if.sv
// ----------------------------------------------------------------------------
// hrhc_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface hrhc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/http_request_header_checker_unit.sv
// ----------------------------------------------------------------------------
// http_request_header_checker_unit
// Byte-wide checker of an HTTP/1.1 request head.
// ----------------------------------------------------------------------------
// Usage: bytes of a request head arrive on req (action 0) or a restart
// beat (action 1) clears the parse state. Every accepted beat produces
// exactly one result beat on res carrying the status, method, version
// digits and field count after that byte.
// Each result is registered in the output register, or the skid entry if that is full.
// Throughput: one beat per cycle while req_ready is high; the single-pass decoder between the
// parse state registers and the result register sets this figure.
// A one-entry result register plus a skid entry keep req_ready high while
// a result waits, so a stalled receiver costs throughput only once both
// entries hold data.
// Reset: parse state returns to the method phase, max_line_bytes to 8000
// and both result entries are emptied.
// Configuration: cfg_we_i writes max_line_bytes; the user writes only while the block is idle, not enforced.
// ----------------------------------------------------------------------------
module http_request_header_checker_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [13:0]       cfg_wdata_i,
  hrhc_stream_if.sink       req,
  hrhc_stream_if.source     res
);
  import hrhc_pkg::*;

  logic [13:0] max_line_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  mb_q [MaxMethodLen];
  logic [MethodIdxW-1:0] mlen_q, mlen_d;
  logic [13:0] llen_q, llen_d;
  logic [2:0]  sub_q, sub_d;
  logic        pcr_q, pcr_d;
  logic [15:0] vpend_q, vpend_d;
  logic [3:0]  vflags_q, vflags_d;
  logic [2:0]  stat_q, stat_d;
  logic [2:0]  meth_q, meth_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  fields_q, fields_d;
  logic        mb_we;

  res_t out_q, skid_q, res_now;
  logic out_vld_q, skid_vld_q;
  logic take;

  assign req.ready = !skid_vld_q;
  assign take = req.valid && req.ready;
  assign res.valid = out_vld_q;
  assign res.data = out_q;

  // Method recognition from the stored method bytes.
  logic [1:0] mclass; // 0 bad, 1 known, 2 not implemented
  logic [2:0] mcode;
  function automatic logic meq(input logic [7:0] a [MaxMethodLen], input int n,
                               input logic [55:0] s);
    logic r;
    r = 1'b1;
    for (int i = 0; i < 7; i++) begin
      if (i < n && i < MaxMethodLen && a[i] != s[55-8*i -: 8]) r = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    mclass = 2'd0;
    mcode = M_GET;
    case (mlen_q)
      MethodIdxW'(3): begin
        if (meq(mb_q, 3, {"GET", 32'h0})) begin mclass = 2'd1; mcode = M_GET; end
        else if (meq(mb_q, 3, {"PUT", 32'h0})) begin mclass = 2'd1; mcode = M_PUT; end
      end
      MethodIdxW'(4): begin
        if (meq(mb_q, 4, {"HEAD", 24'h0})) begin mclass = 2'd1; mcode = M_HEAD; end
        else if (meq(mb_q, 4, {"POST", 24'h0})) begin mclass = 2'd1; mcode = M_POST; end
      end
      MethodIdxW'(5): begin
        if (meq(mb_q, 5, {"TRACE", 16'h0}) || meq(mb_q, 5, {"PATCH", 16'h0}))
          mclass = 2'd2;
      end
      MethodIdxW'(6): begin
        if (meq(mb_q, 6, {"DELETE", 8'h0})) begin mclass = 2'd1; mcode = M_DELETE; end
      end
      MethodIdxW'(7): begin
        if (meq(mb_q, 7, "CONNECT") || meq(mb_q, 7, "OPTIONS")) mclass = 2'd2;
      end
      default: mclass = 2'd0;
    endcase
  end

  always_comb begin
    logic [7:0] b;
    logic [1:0] vlen;
    logic [7:0] last, prv, lastc;
    b = req.data.data_byte;
    phase_d = phase_q; mlen_d = mlen_q; llen_d = llen_q; sub_d = sub_q;
    pcr_d = pcr_q; vpend_d = vpend_q; vflags_d = vflags_q; stat_d = stat_q;
    meth_d = meth_q; ver_d = ver_q; fields_d = fields_q; mb_we = 1'b0;
    vlen = vflags_q[2:1]; last = vpend_q[7:0]; prv = vpend_q[15:8];
    lastc = (last == 8'h20) ? prv : last;
    if (req.data.action) begin
      phase_d = PH_METHOD; mlen_d = '0; llen_d = '0; sub_d = '0; pcr_d = 1'b0;
      vpend_d = '0; vflags_d = '0; stat_d = ST_PARSING; meth_d = '0; ver_d = '0;
      fields_d = '0;
    end else if (phase_q != PH_DONE) begin
      pcr_d = (b == 8'h0d);
      if (llen_q >= max_line_q) begin
        phase_d = PH_DONE;
        if (phase_q == PH_METHOD) stat_d = ST_BAD_REQUEST;
        else if (phase_q < PH_LINE_START) stat_d = ST_URI_LONG;
        else stat_d = ST_FIELD_LONG;
      end else begin
        llen_d = llen_q + 14'd1;
        case (phase_q)
          PH_METHOD: begin
            if (b == 8'h20) begin
              if (mlen_q == '0 || mclass == 2'd0) begin
                phase_d = PH_DONE; stat_d = ST_BAD_REQUEST;
              end else if (mclass == 2'd2) begin
                phase_d = PH_DONE; stat_d = ST_NOT_IMPL;
              end else begin
                meth_d = mcode; phase_d = PH_TARGET; sub_d = '0;
              end
            end else if (mlen_q >= MethodIdxW'(MaxMethodLen)) begin
              phase_d = PH_DONE; stat_d = ST_BAD_REQUEST;
            end else begin
              mb_we = 1'b1; mlen_d = mlen_q + 1'b1;
            end
          end
          PH_TARGET: begin
            if (b == 8'h20) begin
              if (sub_q == '0) begin phase_d = PH_DONE; stat_d = ST_BAD_REQUEST; end
              else begin phase_d = PH_PROTO; sub_d = '0; end
            end else if (b == 8'h0a && pcr_q) begin
              phase_d = PH_DONE; stat_d = ST_BAD_REQUEST;
            end else sub_d = 3'd1;
          end
          PH_PROTO: begin
            if (sub_q >= 3'd5 || b != proto_char(sub_q)) begin
              phase_d = PH_DONE; stat_d = ST_BAD_REQUEST;
            end else begin
              sub_d = sub_q + 3'd1;
              if (sub_q == 3'd4) phase_d = PH_MAJOR;
            end
          end
          PH_MAJOR: begin
            if (b >= 8'h30 && b <= 8'h39) begin
              ver_d = {b[3:0], 4'h0}; phase_d = PH_DOT;
            end else begin phase_d = PH_DONE; stat_d = ST_BAD_REQUEST; end
          end
          PH_DOT: begin
            if (b == 8'h2e) phase_d = PH_MINOR;
            else begin phase_d = PH_DONE; stat_d = ST_BAD_REQUEST; end
          end
          PH_MINOR: begin
            if (b >= 8'h30 && b <= 8'h39) begin
              ver_d = {ver_q[7:4], b[3:0]}; phase_d = PH_REQ_CR;
            end else begin phase_d = PH_DONE; stat_d = ST_BAD_REQUEST; end
          end
          PH_REQ_CR: begin
            if (b == 8'h0d) phase_d = PH_REQ_LF;
            else begin phase_d = PH_DONE; stat_d = ST_BAD_REQUEST; end
          end
          PH_REQ_LF: begin
            if (b == 8'h0a) begin phase_d = PH_LINE_START; llen_d = '0; end
            else begin phase_d = PH_DONE; stat_d = ST_BAD_REQUEST; end
          end
          PH_LINE_START: begin
            if (b == 8'h0d) phase_d = PH_LINE_LF;
            else if (is_tchar(b)) phase_d = PH_NAME;
            else begin phase_d = PH_DONE; stat_d = ST_BAD_REQUEST; end
          end
          PH_LINE_LF: begin
            phase_d = PH_DONE;
            stat_d = (b == 8'h0a) ? ST_COMPLETE : ST_BAD_REQUEST;
          end
          PH_NAME: begin
            if (b == 8'h3a) begin
              phase_d = PH_VALUE; vflags_d = '0; vpend_d = '0;
            end else if (!is_tchar(b)) begin
              phase_d = PH_DONE; stat_d = ST_BAD_REQUEST;
            end
          end
          PH_VALUE: begin
            if (pcr_q) begin
              if (b != 8'h0a) begin
                phase_d = PH_DONE; stat_d = ST_BAD_REQUEST;
              end else if (vlen != 2'd0 && !(vlen == 2'd1 && last == 8'h20) &&
                           (!vflags_q[3] || !is_vchar(lastc))) begin
                phase_d = PH_DONE; stat_d = ST_BAD_REQUEST;
              end else begin
                if (fields_q != 8'hff) fields_d = fields_q + 8'd1;
                phase_d = PH_LINE_START; llen_d = '0;
              end
            end else if (b == 8'h0d) begin
              // A CR waits for the following LF.
            end else if (!(is_vchar(b) || b == 8'h20 || b == 8'h09 || b[7])) begin
              phase_d = PH_DONE; stat_d = ST_BAD_REQUEST;
            end else if (!vflags_q[0] && b == 8'h20) begin
              vflags_d[0] = 1'b1;
            end else begin
              vflags_d[0] = 1'b1;
              if (vlen == 2'd0 && is_vchar(b)) vflags_d[3] = 1'b1;
              vflags_d[2:1] = (vlen < 2'd2) ? vlen + 2'd1 : vlen;
              vpend_d = {vpend_q[7:0], b};
            end
          end
          default: begin phase_d = PH_DONE; stat_d = ST_BAD_REQUEST; end
        endcase
      end
    end
    res_now.status = stat_d;
    res_now.method_code = meth_d;
    res_now.major_version = ver_d[7:4];
    res_now.minor_version = ver_d[3:0];
    res_now.field_count = fields_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= MaxLineReset;
      phase_q <= PH_METHOD; mlen_q <= '0; llen_q <= '0; sub_q <= '0; pcr_q <= 1'b0;
      vpend_q <= '0; vflags_q <= '0; stat_q <= '0; meth_q <= '0; ver_q <= '0;
      fields_q <= '0;
    end else begin
      if (cfg_we_i) max_line_q <= cfg_wdata_i;
      if (take) begin
        phase_q <= phase_d; mlen_q <= mlen_d; llen_q <= llen_d; sub_q <= sub_d;
        pcr_q <= pcr_d; vpend_q <= vpend_d; vflags_q <= vflags_d; stat_q <= stat_d;
        meth_q <= meth_d; ver_q <= ver_d; fields_q <= fields_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && mb_we) mb_q[mlen_q[MethodIdxW-1:0] < MethodIdxW'(MaxMethodLen) ?
                            mlen_q : '0] <= req.data.data_byte;
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0; skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || res.ready) begin
        out_vld_q <= skid_vld_q || take;
        skid_vld_q <= 1'b0;
      end else if (take) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || res.ready) begin
      out_q <= skid_vld_q ? skid_q : res_now;
      if (skid_vld_q && take) skid_q <= res_now;
    end else if (take) begin
      skid_q <= res_now;
    end
  end
endmodule

// File: rtl/core/hrhc_checker.sv
// ----------------------------------------------------------------------------
// hrhc_checker
// Port-level checks of the request head checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "http_request_header_checker_unit_defines.svh"
module hrhc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] res_status,
  input logic [7:0] res_field_count
);
  // A stalled result beat keeps its payload.
  `HRHC_ASSERT(a_res_hold, clk_i, rst_ni, res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_field_count))
  // After an accepted beat, res_valid is high in the next cycle.
  `HRHC_ASSERT(a_res_follows, clk_i, rst_ni, req_valid && req_ready |=> res_valid)
  // Status never goes beyond its last code.
  `HRHC_ASSERT(a_status_range, clk_i, rst_ni, res_valid |-> res_status <= 3'd5)
  // Nothing is offered while in reset.
  `HRHC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !res_valid || rst_ni)
endmodule

bind http_request_header_checker_unit hrhc_checker u_hrhc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready), .res_status(res.data.status),
  .res_field_count(res.data.field_count)
);

// File: sim/hrhc_head_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhc_head_checker
// Watches the request and result channels of the HTTP request head checker,
// works out the result that each accepted beat should leave behind and
// compares every result beat against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module hrhc_head_checker
  import hrhc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,
  hrhc_stream_if      req_mon,
  hrhc_stream_if      res_mon,
  output int          err_count_o,
  output int          outstanding_o
);
  localparam int NotImplCode = 8;
  localparam int UnknownCode = 9;

  logic [13:0] line_max;
  phase_e      ph;
  logic [7:0]  mbytes [MaxMethodLen];
  int          mlen;
  int          llen;
  int          sub;
  bit          prev_cr;
  logic [15:0] vpend;
  logic [3:0]  vflags;
  status_e     st;
  logic [2:0]  meth;
  logic [7:0]  vers;
  int          nfields;
  res_t        expected_q [$];

  assign outstanding_o = expected_q.size();

  function automatic bit vchar_ok(logic [7:0] b);
    return b >= 8'h21 && b <= 8'h7e;
  endfunction

  function automatic bit token_ok(logic [7:0] b);
    bit delim;
    delim = 0;
    case (b)
      8'h22, 8'h28, 8'h29, 8'h2c, 8'h2f, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
      8'h40, 8'h5b, 8'h5c, 8'h5d, 8'h7b, 8'h7d: delim = 1;
      default: delim = 0;
    endcase
    return vchar_ok(b) && !delim;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    err_count_o++;
  endtask

  task automatic clear_parse();
    ph = PH_METHOD;
    mlen = 0;
    llen = 0;
    sub = 0;
    prev_cr = 0;
    vpend = '0;
    vflags = '0;
    st = ST_PARSING;
    meth = '0;
    vers = '0;
    nfields = 0;
  endtask

  task automatic conclude(status_e s);
    st = s;
    ph = PH_DONE;
  endtask

  function automatic int lookup_method();
    logic [55:0] w;
    w = '0;
    for (int k = 0; k < mlen; k++) w[55-8*k -: 8] = mbytes[k];
    case (mlen)
      3: begin
        if (w[55:32] == "GET") return M_GET;
        if (w[55:32] == "PUT") return M_PUT;
      end
      4: begin
        if (w[55:24] == "HEAD") return M_HEAD;
        if (w[55:24] == "POST") return M_POST;
      end
      5: if (w[55:16] == "TRACE" || w[55:16] == "PATCH") return NotImplCode;
      6: if (w[55:8] == "DELETE") return M_DELETE;
      7: if (w == "CONNECT" || w == "OPTIONS") return NotImplCode;
      default: ;
    endcase
    return UnknownCode;
  endfunction

  task automatic close_value();
    int n;
    logic [7:0] last, tail;
    n = vflags[2:1];
    last = vpend[7:0];
    if (n != 0 && !(n == 1 && last == 8'h20)) begin
      tail = (last == 8'h20) ? vpend[15:8] : last;
      if (!vflags[3] || !vchar_ok(tail)) begin
        conclude(ST_BAD_REQUEST);
        return;
      end
    end
    if (nfields < 255) nfields++;
    ph = PH_LINE_START;
    llen = 0;
  endtask

  task automatic value_step(logic [7:0] b);
    int n;
    if (prev_cr) begin
      if (b == 8'h0a) close_value();
      else conclude(ST_BAD_REQUEST);
      return;
    end
    if (b == 8'h0d) return;
    if (!(vchar_ok(b) || b == 8'h20 || b == 8'h09 || b >= 8'h80)) begin
      conclude(ST_BAD_REQUEST);
      return;
    end
    if (!vflags[0]) begin
      vflags[0] = 1;
      if (b == 8'h20) return;
    end
    n = vflags[2:1];
    if (n == 0 && vchar_ok(b)) vflags[3] = 1;
    if (n < 2) n++;
    vflags[2:1] = n[1:0];
    vpend = {vpend[7:0], b};
  endtask

  task automatic parse_byte(logic [7:0] b);
    int code;
    if (llen >= line_max) begin
      if (ph == PH_METHOD) conclude(ST_BAD_REQUEST);
      else if (ph < PH_LINE_START) conclude(ST_URI_LONG);
      else conclude(ST_FIELD_LONG);
      return;
    end
    llen++;
    case (ph)
      PH_METHOD: begin
        if (b == 8'h20) begin
          if (mlen == 0) begin
            conclude(ST_BAD_REQUEST);
          end else begin
            code = lookup_method();
            if (code == NotImplCode) conclude(ST_NOT_IMPL);
            else if (code == UnknownCode) conclude(ST_BAD_REQUEST);
            else begin
              meth = code[2:0];
              ph = PH_TARGET;
              sub = 0;
            end
          end
        end else if (mlen >= MaxMethodLen) begin
          conclude(ST_BAD_REQUEST);
        end else begin
          mbytes[mlen] = b;
          mlen++;
        end
      end
      PH_TARGET: begin
        if (b == 8'h20) begin
          if (sub == 0) conclude(ST_BAD_REQUEST);
          else begin
            ph = PH_PROTO;
            sub = 0;
          end
        end else if (b == 8'h0a && prev_cr) begin
          conclude(ST_BAD_REQUEST);
        end else begin
          sub = 1;
        end
      end
      PH_PROTO: begin
        if (sub >= 5 || b != proto_char(3'(sub))) conclude(ST_BAD_REQUEST);
        else begin
          sub++;
          if (sub == 5) ph = PH_MAJOR;
        end
      end
      PH_MAJOR: begin
        if (b >= "0" && b <= "9") begin
          vers = {b[3:0], 4'h0};
          ph = PH_DOT;
        end else conclude(ST_BAD_REQUEST);
      end
      PH_DOT: if (b == ".") ph = PH_MINOR; else conclude(ST_BAD_REQUEST);
      PH_MINOR: begin
        if (b >= "0" && b <= "9") begin
          vers[3:0] = b[3:0];
          ph = PH_REQ_CR;
        end else conclude(ST_BAD_REQUEST);
      end
      PH_REQ_CR: if (b == 8'h0d) ph = PH_REQ_LF; else conclude(ST_BAD_REQUEST);
      PH_REQ_LF: begin
        if (b == 8'h0a) begin
          ph = PH_LINE_START;
          llen = 0;
        end else conclude(ST_BAD_REQUEST);
      end
      PH_LINE_START: begin
        if (b == 8'h0d) ph = PH_LINE_LF;
        else if (token_ok(b)) ph = PH_NAME;
        else conclude(ST_BAD_REQUEST);
      end
      PH_LINE_LF: conclude(b == 8'h0a ? ST_COMPLETE : ST_BAD_REQUEST);
      PH_NAME: begin
        if (b == ":") begin
          ph = PH_VALUE;
          vflags = '0;
          vpend = '0;
        end else if (!token_ok(b)) conclude(ST_BAD_REQUEST);
      end
      PH_VALUE: value_step(b);
      default: conclude(ST_BAD_REQUEST);
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    req_t beat;
    res_t got, want;
    if (!rst_ni) begin
      line_max = MaxLineReset;
      clear_parse();
      expected_q.delete();
      err_count_o = 0;
    end else begin
      if (cfg_we_i) line_max = cfg_wdata_i;
      if (req_mon.valid && req_mon.ready) begin
        beat = req_mon.data;
        if (beat.action) clear_parse();
        else if (ph != PH_DONE) begin
          parse_byte(beat.data_byte);
          prev_cr = (beat.data_byte == 8'h0d);
        end
        expected_q.push_back('{st, meth, vers[7:4], vers[3:0], nfields[7:0]});
      end
      if (res_mon.valid && res_mon.ready) begin
        got = res_mon.data;
        if (expected_q.size() == 0) begin
          report("unexpected result beat", got.status, -1);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.method_code !== want.method_code)
            report("method_code", got.method_code, want.method_code);
          if (got.major_version !== want.major_version)
            report("major_version", got.major_version, want.major_version);
          if (got.minor_version !== want.minor_version)
            report("minor_version", got.minor_version, want.minor_version);
          if (got.field_count !== want.field_count)
            report("field_count", got.field_count, want.field_count);
        end
      end
    end
  end
endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds request heads, restarts and corrupted byte streams to the HTTP
// request head checker under random stalls and several line limits; the
// checker instance predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import hrhc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [13:0] cfg_wdata_i;
  bit          calm;
  int          err_count;
  int          outstanding;
  int          sent;
  string       crlf;

  hrhc_stream_if #(.payload_t(req_t)) req_ch ();
  hrhc_stream_if #(.payload_t(res_t)) res_ch ();

  http_request_header_checker_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch),
    .res        (res_ch)
  );

  hrhc_head_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_mon      (req_ch),
    .res_mon      (res_ch),
    .err_count_o  (err_count),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("** http_request_header_checker_unit: FAILED **");
    $finish;
  end

  always @(posedge clk_i) begin
    res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
  end

  task automatic send_beat(bit act, logic [7:0] b);
    bit hs;
    if (!calm && $urandom_range(99) < 27) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= '{action: act, data_byte: b};
    forever begin
      @(negedge clk_i) hs = req_ch.ready;
      @(posedge clk_i);
      if (hs) break;
    end
    sent++;
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_beat(1'b0, s[k]);
  endtask

  task automatic restart();
    send_beat(1'b1, 8'($urandom));
  endtask

  // Waits for every result beat, then writes the line limit.
  task automatic set_line_limit(logic [13:0] v);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_token_byte();
    string tok;
    tok = "abcXYZ09-!#$%&'*+.^_`|~";
    return tok[$urandom_range(tok.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_value_byte();
    case ($urandom_range(5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'($urandom_range(255, 128));
      default: return 8'($urandom_range(8'h7e, 8'h21));
    endcase
  endfunction

  // A mostly well-formed request head with random content; one byte may be
  // replaced with noise or the head cut short, so that error paths are reached.
  task automatic send_random_request();
    string methods [10];
    string s;
    int noise;
    methods = '{"GET", "HEAD", "PUT", "DELETE", "POST", "CONNECT", "OPTIONS",
                "TRACE", "PATCH", "GETX"};
    s = {methods[$urandom_range(9)], " /"};
    repeat ($urandom_range(6)) s = {s, string'(8'($urandom_range(8'h7e, 8'h21)))};
    s = {s, " HTTP/", string'(8'("0" + $urandom_range(9))), ".",
         string'(8'("0" + $urandom_range(9))), crlf};
    repeat ($urandom_range(4)) begin
      repeat ($urandom_range(4, 1)) s = {s, string'(pick_token_byte())};
      s = {s, ":"};
      if ($urandom_range(1)) s = {s, " "};
      repeat ($urandom_range(5)) s = {s, string'(pick_value_byte())};
      if ($urandom_range(2) == 0) s = {s, " "};
      s = {s, crlf};
    end
    s = {s, crlf};
    noise = $urandom_range(99);
    if (noise < 25) s[$urandom_range(s.len() - 1)] = 8'($urandom);
    if (noise >= 90) s = s.substr(0, $urandom_range(s.len() - 1));
    restart();
    send_text(s);
    // Bytes after the end of a head are ignored but still answered.
    repeat ($urandom_range(2)) send_beat(1'b0, 8'($urandom));
  endtask

  initial begin
    logic [13:0] limits [5];
    limits = '{14'd16, 14'd16383, 14'd5, 14'd40, 14'd8000};
    crlf = "\015\012";
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
    calm = 0;
    sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed heads: accepted, not implemented, malformed request lines,
    // bare CR in the target, value edge bytes and bad value bytes.
    send_text({"GET /a HTTP/1.1", crlf, "Host: x", crlf, crlf});
    restart();
    send_text("CONNECT ");
    restart();
    send_text("FOOBARBAZ ");
    restart();
    send_text(" ");
    restart();
    send_text("PUT  ");
    restart();
    send_text({"DELETE /\015x HTTP/9.0", crlf, "A:\377 b ", crlf, "B:", crlf,
               crlf});
    restart();
    send_text({"POST /x HTTP/1.1", crlf, "C: \001", crlf});
    restart();
    send_text({"HEAD / HTTP/0.9", crlf, "D:v\015z", crlf, "\015x"});

    for (int p = 0; p < 5; p++) begin
      set_line_limit(limits[p]);
      while (sent < 150 + 40 * (p + 1)) begin
        calm = (p == 3);
        send_random_request();
      end
    end
    calm = 0;
    set_line_limit(14'($urandom_range(16383, 16)));
    repeat (2) send_random_request();

    req_ch.valid <= 1'b0;
    fork
      while (outstanding != 0) @(posedge clk_i);
      repeat (20000) @(posedge clk_i);
    join_any
    disable fork;
    repeat (5) @(posedge clk_i);
    if (err_count == 0 && outstanding == 0) begin
      $display("** http_request_header_checker_unit: PASSED **");
    end else begin
      $display("** http_request_header_checker_unit: FAILED **");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/hrhc_pkg.sv
rtl/core/hrhc_stream_if.sv
rtl/core/http_request_header_checker_unit.sv
rtl/core/hrhc_checker.sv
sim/hrhc_head_checker.sv
sim/testbench.sv
